// ===== design/bftm_pkg.sv =====
// Shared types, constants and helpers for the byte frame tone modulator.
// No dependencies; imported by byte_frame_tone_modulator.
package bftm_pkg;

  // Half-symbol length limits and widths
  localparam int unsigned MAX_HALF_LEN = 4096;
  localparam int unsigned SPB_W    = 13;  // half length / wave length width
  localparam int unsigned POS_W    = 12;  // sample and phase position width
  localparam int unsigned CYC_W    = 8;   // cycle count width
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned QUEUE_W  = 22;  // pending symbol codes
  localparam int unsigned LEFT_W   = 4;
  localparam int unsigned DIV_STEPS = SPB_W;  // one quotient bit per step
  localparam int unsigned DCNT_W   = $clog2(DIV_STEPS);

  // Input word commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Symbol codes
  localparam logic [1:0] SYM_BIT0  = 2'd0;
  localparam logic [1:0] SYM_BIT1  = 2'd1;
  localparam logic [1:0] SYM_START = 2'd2;
  localparam logic [1:0] SYM_END   = 2'd3;

  // Data symbols per byte: eight data bits and parity
  localparam logic [LEFT_W-1:0] BYTE_SYMBOLS = 4'd9;

  // Register indexes
  localparam logic [2:0] REG_SPB    = 3'd0;
  localparam logic [2:0] REG_LOW    = 3'd1;
  localparam logic [2:0] REG_MEDIUM = 3'd2;
  localparam logic [2:0] REG_HIGH   = 3'd3;
  localparam logic [2:0] REG_AMP    = 3'd4;

  // Register reset values
  localparam logic [SPB_W-1:0] SPB_RST    = 13'd256;
  localparam logic [CYC_W-1:0] LOW_RST    = 8'd1;
  localparam logic [CYC_W-1:0] MEDIUM_RST = 8'd2;
  localparam logic [CYC_W-1:0] HIGH_RST   = 8'd4;
  localparam logic [AMP_W-1:0] AMP_RST    = 15'd16384;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  // Input word
  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       first_of_frame;
    logic       last_of_frame;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    accepted;
    logic                    busy_res;
    logic                    frame_end;
  } out_word_t;

  // Cycle count of one half of a symbol
  function automatic logic [CYC_W-1:0] cycles_for(
    input logic [1:0]       sym,
    input logic             half,
    input logic [CYC_W-1:0] low_c,
    input logic [CYC_W-1:0] med_c,
    input logic [CYC_W-1:0] high_c
  );
    logic [CYC_W-1:0] c;
    case (sym)
      SYM_START: c = half ? high_c : low_c;
      SYM_END:   c = half ? low_c  : high_c;
      SYM_BIT0:  c = half ? low_c  : med_c;
      default:   c = half ? med_c  : low_c;
    endcase
    return c;
  endfunction

endpackage

// ===== design/byte_frame_tone_modulator.sv =====
// Byte frame tone modulator: symbol queue, square-wave sample generator, config regs.
// Depends on bftm_pkg (types, constants, cycles_for).
// A tick word that opens a half-symbol runs 13 steps of the restoring divider (ST_DIV)
// that sizes the wave, then steps in ST_EXEC once the result slot is free; the next word is
// taken after the return to ST_IDLE. Every other word steps at its accept edge: result valid
// the next cycle, one word per cycle. Input stalls while busy or while a result word is held.
// Reset (async, active low) loads register defaults, empties the symbol queue, idles.
module byte_frame_tone_modulator
  import bftm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_word_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_word_t       out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  // Configuration registers
  logic [SPB_W-1:0] spb_q;
  logic [CYC_W-1:0] low_q, med_q, high_q;
  logic [AMP_W-1:0] amp_q;
  logic [2:0]       reg_idx;
  logic             cfg_we;

  // Sequencer and modulator state
  state_e              state_q, state_d;
  logic [QUEUE_W-1:0]  pend_q, pend_d;
  logic [LEFT_W-1:0]   left_q, left_d;
  logic                second_q, second_d;
  logic [POS_W-1:0]    spos_q, spos_d;
  logic [SPB_W-1:0]    wave_q, wave_d;
  logic [POS_W-1:0]    phase_q, phase_d;
  logic [CYC_W-1:0]    cyc_q, cyc_d;
  logic [CYC_W-1:0]    hcyc_q, hcyc_d;

  // Divider registers
  logic [CYC_W-1:0]    rem_q, rem_d;
  logic [SPB_W-1:0]    quo_q, quo_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;

  // Output register
  logic                out_valid_q;
  out_word_t           out_q;

  // Combinational helpers
  logic [SPB_W-1:0]    slen;
  logic                slot_free;
  logic                in_fire;
  logic                need_div;
  logic                do_step;
  logic                step_cmd;
  logic [CYC_W:0]      trial;
  logic                trial_ge;
  logic [CYC_W:0]      trial_sub;
  logic [SPB_W-1:0]    quo_next;
  logic [POS_W-1:0]    half_wave;
  logic [SPB_W-1:0]    phase_inc;
  logic [SPB_W-1:0]    spos_inc;
  logic [15:0]         pos_amp;
  logic [1:0]          cur_sym;
  logic [19:0]         body;
  logic [1:0]          end_code;
  out_word_t           res;

  // Clamp the half-symbol length
  always_comb begin
    if (spb_q < SPB_W'(2)) begin
      slen = SPB_W'(2);
    end else if (spb_q > SPB_W'(MAX_HALF_LEN)) begin
      slen = SPB_W'(MAX_HALF_LEN);
    end else begin
      slen = spb_q;
    end
  end

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_SPB:    prdata = 32'(spb_q);
      REG_LOW:    prdata = 32'(low_q);
      REG_MEDIUM: prdata = 32'(med_q);
      REG_HIGH:   prdata = 32'(high_q);
      REG_AMP:    prdata = 32'(amp_q);
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q  <= SPB_RST;
      low_q  <= LOW_RST;
      med_q  <= MEDIUM_RST;
      high_q <= HIGH_RST;
      amp_q  <= AMP_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_SPB:    spb_q  <= pwdata[SPB_W-1:0];
        REG_LOW:    low_q  <= pwdata[CYC_W-1:0];
        REG_MEDIUM: med_q  <= pwdata[CYC_W-1:0];
        REG_HIGH:   high_q <= pwdata[CYC_W-1:0];
        REG_AMP:    amp_q  <= pwdata[AMP_W-1:0];
        default:    ;
      endcase
    end
  end

  // Handshake
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !slot_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign need_div   = (in_data_i.cmd == CMD_TICK) && (left_q != '0) && (spos_q == '0);
  assign cur_sym    = pend_q[1:0];

  // Divider step: shift in one dividend bit, subtract when it fits
  assign trial     = {rem_q, quo_q[SPB_W-1]};
  assign trial_ge  = trial >= {1'b0, hcyc_q};
  assign trial_sub = trial - {1'b0, hcyc_q};
  assign quo_next  = {quo_q[SPB_W-2:0], trial_ge};

  // Symbol queue contents for a load: data bits, parity, then the end marker slot
  always_comb begin
    end_code = in_data_i.last_of_frame ? SYM_END : SYM_BIT0;
    for (int i = 0; i < 8; i++) begin
      body[2*i +: 2] = {1'b0, in_data_i.data_byte[i]};
    end
    body[17:16] = {1'b0, ^in_data_i.data_byte};
    body[19:18] = end_code;
  end

  assign half_wave = wave_q[SPB_W-1:1];
  assign phase_inc = SPB_W'(phase_q) + SPB_W'(1);
  assign spos_inc  = SPB_W'(spos_q) + SPB_W'(1);
  assign pos_amp   = {1'b0, amp_q};

  // Sequencer and sample step
  always_comb begin
    state_d  = state_q;
    pend_d   = pend_q;
    left_d   = left_q;
    second_d = second_q;
    spos_d   = spos_q;
    wave_d   = wave_q;
    phase_d  = phase_q;
    cyc_d    = cyc_q;
    hcyc_d   = hcyc_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dcnt_d   = dcnt_q;
    do_step  = 1'b0;
    res      = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (need_div) begin
            // open a half: latch its cycle count and size the wave
            hcyc_d  = cycles_for(cur_sym, second_q, low_q, med_q, high_q);
            phase_d = '0;
            cyc_d   = '0;
            rem_d   = '0;
            quo_d   = slen;
            dcnt_d  = '0;
            state_d = ST_DIV;
          end else begin
            do_step = 1'b1;
          end
        end
      end
      ST_DIV: begin
        rem_d  = trial_ge ? trial_sub[CYC_W-1:0] : trial[CYC_W-1:0];
        quo_d  = quo_next;
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
          if (hcyc_q == '0 || SPB_W'(hcyc_q) > slen) begin
            wave_d = '0;
          end else begin
            wave_d = quo_next;
          end
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          do_step = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    step_cmd = (state_q == ST_EXEC) || (in_data_i.cmd == CMD_TICK);

    if (do_step) begin
      if (!step_cmd) begin
        // load: queue the byte's symbols while idle
        if (left_q == '0) begin
          if (in_data_i.first_of_frame) begin
            pend_d = {body, SYM_START};
          end else begin
            pend_d = {2'b00, body};
          end
          left_d = BYTE_SYMBOLS + LEFT_W'(in_data_i.first_of_frame)
                 + LEFT_W'(in_data_i.last_of_frame);
          second_d = 1'b0;
          spos_d   = '0;
          phase_d  = '0;
          cyc_d    = '0;
          res.accepted = 1'b1;
        end
      end else if (left_q != '0) begin
        // tick: emit one sample of the current wave
        if (wave_q != '0 && cyc_q < hcyc_q) begin
          if (phase_q < half_wave) begin
            res.sample = pos_amp;
          end else if (SPB_W'(phase_q) < {half_wave, 1'b0}) begin
            res.sample = 16'd0 - pos_amp;
          end
          if (phase_inc >= wave_q) begin
            phase_d = '0;
            cyc_d   = cyc_q + CYC_W'(1);
          end else begin
            phase_d = phase_inc[POS_W-1:0];
          end
        end
        // advance through the half and the symbol
        if (spos_inc >= slen) begin
          spos_d = '0;
          if (second_q) begin
            res.frame_end = (cur_sym == SYM_END);
            second_d = 1'b0;
            pend_d   = {2'b00, pend_q[QUEUE_W-1:2]};
            left_d   = left_q - LEFT_W'(1);
          end else begin
            second_d = 1'b1;
          end
        end else begin
          spos_d = spos_inc[POS_W-1:0];
        end
      end
      res.busy_res = (left_d != '0);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= '0;
      left_q      <= '0;
      second_q    <= 1'b0;
      spos_q      <= '0;
      wave_q      <= '0;
      phase_q     <= '0;
      cyc_q       <= '0;
      hcyc_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      left_q   <= left_d;
      second_q <= second_d;
      spos_q   <= spos_d;
      wave_q   <= wave_d;
      phase_q  <= phase_d;
      cyc_q    <= cyc_d;
      hcyc_q   <= hcyc_d;
      dcnt_q   <= dcnt_d;
      // hold the result word until taken
      if (do_step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (do_step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for byte_frame_tone_modulator: sends load and tick words, predicts each
// result word at the input handshake and checks it field by field at the output.
// Depends on bftm_pkg and the block's RTL; configures the block over its APB port.
module tb
  import bftm_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_WORDS = 600;
  localparam int unsigned ALL_TICKS    = 32'hFFFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_word_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_word_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  byte_frame_tone_modulator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Predicted register contents
  logic [SPB_W-1:0] cfg_spb;
  logic [CYC_W-1:0] cfg_low;
  logic [CYC_W-1:0] cfg_med;
  logic [CYC_W-1:0] cfg_high;
  logic [AMP_W-1:0] cfg_amp;

  // Predicted modulator state
  logic [QUEUE_W-1:0] sym_queue;
  int unsigned        syms_left;
  logic               in_second_half;
  int unsigned        pos_in_half;
  int unsigned        wave_len;
  int unsigned        phase_pos;
  int unsigned        cycle_idx;
  int unsigned        half_cyc;

  out_word_t   expected_words[$];
  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_in_play = 0;
  int unsigned gap_pct = 35;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d words still expected",
               cycle_count, expected_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("ERROR at %0t, result %0d, %s: got %0d expected %0d",
             $realtime, result_count, what, got, want);
  endtask

  // Clear the model to its reset state
  function automatic void reset_model();
    cfg_spb        = SPB_RST;
    cfg_low        = LOW_RST;
    cfg_med        = MEDIUM_RST;
    cfg_high       = HIGH_RST;
    cfg_amp        = AMP_RST;
    sym_queue      = '0;
    syms_left      = 0;
    in_second_half = 1'b0;
    pos_in_half    = 0;
    wave_len       = 0;
    phase_pos      = 0;
    cycle_idx      = 0;
    half_cyc       = 0;
  endfunction

  // Half-symbol length, held within the supported range
  function automatic int unsigned half_len();
    if (cfg_spb < 2) return 2;
    if (cfg_spb > MAX_HALF_LEN) return MAX_HALF_LEN;
    return 32'(cfg_spb);
  endfunction

  // Square cycles for one half of a symbol: markers and bits use low/medium/high
  function automatic int unsigned half_cycle_count(input logic [1:0] sym, input logic half);
    logic [CYC_W-1:0] first_half, second_half;
    case (sym)
      SYM_START: begin
        first_half  = cfg_low;
        second_half = cfg_high;
      end
      SYM_END: begin
        first_half  = cfg_high;
        second_half = cfg_low;
      end
      SYM_BIT0: begin
        first_half  = cfg_med;
        second_half = cfg_low;
      end
      default: begin
        first_half  = cfg_low;
        second_half = cfg_med;
      end
    endcase
    return 32'(half ? second_half : first_half);
  endfunction

  // Advance the model by one accepted word and return the result it causes
  function automatic out_word_t modulate_step(input in_word_t w);
    out_word_t          r;
    logic [QUEUE_W-1:0] q;
    int unsigned        n, slen, hw;
    logic               par;
    logic [1:0]         sym;
    r = '0;
    if (w.cmd == CMD_LOAD) begin
      if (syms_left == 0) begin
        q   = '0;
        n   = 0;
        par = 1'b0;
        if (w.first_of_frame) begin
          q[2*n +: 2] = SYM_START;
          n++;
        end
        for (int i = 0; i < 8; i++) begin
          q[2*n +: 2] = {1'b0, w.data_byte[i]};
          par ^= w.data_byte[i];
          n++;
        end
        q[2*n +: 2] = {1'b0, par};
        n++;
        if (w.last_of_frame) begin
          q[2*n +: 2] = SYM_END;
          n++;
        end
        sym_queue      = q;
        syms_left      = n;
        in_second_half = 1'b0;
        pos_in_half    = 0;
        phase_pos      = 0;
        cycle_idx      = 0;
        r.accepted     = 1'b1;
      end
    end else if (syms_left != 0) begin
      sym  = sym_queue[1:0];
      slen = half_len();
      // Size the wave at the first sample of each half
      if (pos_in_half == 0) begin
        half_cyc  = half_cycle_count(sym, in_second_half);
        wave_len  = (half_cyc != 0 && half_cyc <= slen) ? slen / half_cyc : 0;
        phase_pos = 0;
        cycle_idx = 0;
      end
      hw = wave_len / 2;
      if (wave_len != 0 && cycle_idx < half_cyc) begin
        if (phase_pos < hw) r.sample = {1'b0, cfg_amp};
        else if (phase_pos < 2 * hw) r.sample = -$signed({1'b0, cfg_amp});
        phase_pos++;
        if (phase_pos >= wave_len) begin
          phase_pos = 0;
          cycle_idx++;
        end
      end
      // Step to the next half, then to the next symbol
      pos_in_half++;
      if (pos_in_half >= slen) begin
        pos_in_half = 0;
        if (in_second_half) begin
          if (sym == SYM_END) r.frame_end = 1'b1;
          in_second_half = 1'b0;
          sym_queue      = sym_queue >> 2;
          syms_left--;
        end else begin
          in_second_half = 1'b1;
        end
      end
    end
    r.busy_res = (syms_left != 0);
    return r;
  endfunction

  // Sender gap: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) >= gap_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_word_t tick_word();
    in_word_t w;
    w.cmd            = CMD_TICK;
    w.data_byte      = 8'($urandom_range(0, 255));
    w.first_of_frame = 1'($urandom_range(0, 1));
    w.last_of_frame  = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Offer one word, hold it until taken, then record its prediction
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_words.push_back(modulate_step(w));
  endtask

  // Drop valid and hold off until every expected word has come
  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup then access; upper bus bits carry junk
  task automatic write_reg(input logic [2:0] idx, input int unsigned value);
    int unsigned width;
    logic [31:0] bus_word;
    case (idx)
      REG_SPB: width = SPB_W;
      REG_AMP: width = AMP_W;
      default: width = CYC_W;
    endcase
    bus_word = (value & ((32'd1 << width) - 1)) | ($urandom << width);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= bus_word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_SPB:    cfg_spb  = bus_word[SPB_W-1:0];
      REG_LOW:    cfg_low  = bus_word[CYC_W-1:0];
      REG_MEDIUM: cfg_med  = bus_word[CYC_W-1:0];
      REG_HIGH:   cfg_high = bus_word[CYC_W-1:0];
      default:    cfg_amp  = bus_word[AMP_W-1:0];
    endcase
  endtask

  task automatic apply_config(input int unsigned spb, input int unsigned lo,
                              input int unsigned md, input int unsigned hi,
                              input int unsigned amp);
    wait_results();
    write_reg(REG_SPB, spb);
    write_reg(REG_LOW, lo);
    write_reg(REG_MEDIUM, md);
    write_reg(REG_HIGH, hi);
    write_reg(REG_AMP, amp);
  endtask

  // Offer the load word for one byte
  task automatic load_byte(input logic [7:0] data, input logic first, input logic last);
    in_word_t w;
    w.cmd            = CMD_LOAD;
    w.data_byte      = data;
    w.first_of_frame = first;
    w.last_of_frame  = last;
    send_word(w);
    words_in_play++;
  endtask

  // Tick until the queued symbols are played or max_ticks is reached; mix in refused loads
  task automatic play_ticks(input int unsigned max_ticks, input int unsigned noise_pct);
    in_word_t    w;
    int unsigned ticks;
    ticks = 0;
    while (syms_left != 0 && ticks < max_ticks) begin
      if ($urandom_range(0, 499) == 0) wait_results();
      if ($urandom_range(0, 99) < noise_pct) begin
        w.cmd            = CMD_LOAD;
        w.data_byte      = 8'($urandom_range(0, 255));
        w.first_of_frame = 1'($urandom_range(0, 1));
        w.last_of_frame  = 1'($urandom_range(0, 1));
        send_word(w);
      end else begin
        send_word(tick_word());
        words_in_play++;
        ticks++;
      end
    end
  endtask

  // Load one byte and tick until its symbols are played
  task automatic play_byte(input logic [7:0] data, input logic first, input logic last,
                           input int unsigned noise_pct);
    load_byte(data, first, last);
    play_ticks(ALL_TICKS, noise_pct);
  endtask

  // Receiver stall: free stretches, short stalls, a few long ones
  initial begin
    int unsigned r;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end else if (r < 90) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(8, 40)) @(posedge clk_i);
      end
    end
  end

  // Check each taken result word against the oldest prediction
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected", int'(out_data_o.sample), 0);
      end else begin
        want = expected_words.pop_front();
        if (out_data_o.sample !== want.sample)
          report_mismatch("sample", int'(out_data_o.sample), int'(want.sample));
        if (out_data_o.accepted !== want.accepted)
          report_mismatch("accepted", int'(out_data_o.accepted), int'(want.accepted));
        if (out_data_o.busy_res !== want.busy_res)
          report_mismatch("busy_res", int'(out_data_o.busy_res), int'(want.busy_res));
        if (out_data_o.frame_end !== want.frame_end)
          report_mismatch("frame_end", int'(out_data_o.frame_end), int'(want.frame_end));
      end
      result_count++;
    end
  end

  // Ticks while idle, part of a byte at reset settings, refused loads while busy,
  // then a shorter half length that ends the current half early
  task automatic test_idle_and_defaults();
    gap_pct = 35;
    repeat (3) send_word(tick_word());
    load_byte(8'h96, 1'b1, 1'b1);
    play_ticks(270, 2);
    wait_results();
    write_reg(REG_SPB, 3);
    play_ticks(ALL_TICKS, 2);
    repeat (2) send_word(tick_word());
  endtask

  // Start and end markers at the shortest halves, spb below range clamped up
  task automatic test_frame_markers();
    apply_config(0, 1, 2, 1, 32767);
    play_byte(8'hFF, 1'b1, 1'b1, 5);
    apply_config(1, 1, 2, 4, 1);
    play_byte(8'h00, 1'b1, 1'b0, 5);
    play_byte(8'h01, 1'b0, 1'b1, 5);
    apply_config(4, 1, 2, 4, 32767);
    play_byte(8'h80, 1'b1, 1'b1, 0);
    send_word(tick_word());
  endtask

  // Zero cycles, too many cycles, odd wave, leftover samples, zero amplitude
  task automatic test_silent_halves();
    apply_config(3, 0, 1, 255, 12345);
    play_byte(8'hA5, 1'b1, 1'b1, 0);
    apply_config(5, 5, 2, 3, 0);
    play_byte(8'h5A, 1'b1, 1'b1, 0);
  endtask

  // Widest register value clamped to the longest half, then cut short
  task automatic test_max_length();
    gap_pct = 3;
    apply_config(32'h1FFF, 3, 255, 128, 32767);
    load_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    play_ticks(150, 0);
    wait_results();
    write_reg(REG_SPB, 2);
    play_ticks(ALL_TICKS, 0);
    gap_pct = 35;
  endtask

  function automatic int unsigned pick_cycles(input int unsigned spb);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return 255;
    if (r < 30) return (spb < 2) ? 2 : spb;
    return $urandom_range(1, 4);
  endfunction

  // Random settings per phase, one or two bytes each, idle ticks in between
  task automatic test_random_frames();
    int unsigned r, spb, amp;
    words_in_play = 0;
    while (words_in_play < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 8) spb = $urandom_range(0, 1);
      else if (r < 85) spb = $urandom_range(2, 8);
      else spb = $urandom_range(9, 16);
      r = $urandom_range(0, 99);
      if (r < 15) amp = 0;
      else if (r < 30) amp = 32767;
      else amp = $urandom_range(0, 32767);
      case ($urandom_range(0, 3))
        0: gap_pct = 0;
        1: gap_pct = 10;
        2: gap_pct = 35;
        default: gap_pct = 60;
      endcase
      apply_config(spb, pick_cycles(spb), pick_cycles(spb), pick_cycles(spb), amp);
      repeat ($urandom_range(1, 2))
        play_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 3);
      repeat ($urandom_range(0, 3)) send_word(tick_word());
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_and_defaults();
    test_frame_markers();
    test_silent_halves();
    test_max_length();
    test_random_frames();

    // Drain, then let the block settle
    wait_results();
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
